// ===== sv/tnrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-node thermal RC stepper package
// Shared types, reset constants and saturating helpers for the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package tnrc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 24;
  localparam int unsigned DiffW = DataW + 1;
  localparam int unsigned AddrW = 4;
  localparam int unsigned BusW  = 32;

  localparam logic [CoefW-1:0] CHAMBER_COND_RST = 24'd5041;
  localparam logic [CoefW-1:0] WALL_COND_RST    = 24'd16384;
  localparam logic [CoefW-1:0] CHAMBER_INVC_RST = 24'd819;
  localparam logic [CoefW-1:0] WALL_INVC_RST    = 24'd32768;

  localparam logic [1:0] REG_CHAMBER_COND = 2'd0;
  localparam logic [1:0] REG_WALL_COND    = 2'd1;
  localparam logic [1:0] REG_CHAMBER_INVC = 2'd2;
  localparam logic [1:0] REG_WALL_INVC    = 2'd3;

  typedef struct packed {
    logic signed [DataW-1:0] heat_input;
    logic signed [DataW-1:0] ambient_temp;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] chamber_temp;
    logic signed [DataW-1:0] wall_temp;
  } out_item_t;

  // Exact difference of two Q16.16 values.
  function automatic logic signed [DiffW-1:0] diff33(input logic signed [DataW-1:0] a,
                                                     input logic signed [DataW-1:0] b);
    diff33 = {a[DataW-1], a} - {b[DataW-1], b};
  endfunction

  // Trapezoidal step: acc + floor((a + b) / 2), saturated to 32 bits.
  function automatic logic signed [DataW-1:0] trap_acc(input logic signed [DataW-1:0] acc,
                                                       input logic signed [DataW-1:0] a,
                                                       input logic signed [DataW-1:0] b);
    logic signed [DataW:0]   sum;
    logic signed [DataW:0]   half;
    logic signed [DataW+1:0] tot;
    sum  = {a[DataW-1], a} + {b[DataW-1], b};
    half = sum >>> 1;
    tot  = {{2{acc[DataW-1]}}, acc} + {half[DataW], half};
    if (tot[DataW+1:DataW-1] == 3'b000 || tot[DataW+1:DataW-1] == 3'b111) begin
      trap_acc = tot[DataW-1:0];
    end else if (tot[DataW+1]) begin
      trap_acc = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      trap_acc = {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/tnrc_mul.sv =====
// ----------------------------------------------------------------------------
// Shared scaling multiplier
// Registers a 33-bit difference times a Q8.16 coefficient, then rounds the
// registered product to Q16.16 and saturates it to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrc_mul (
  input  wire logic                                   clk,
  input  wire logic                                   load,
  input  wire logic signed [tnrc_pkg::DiffW-1:0]      diff,
  input  wire logic        [tnrc_pkg::CoefW-1:0]      coef,
  output logic signed      [tnrc_pkg::DataW-1:0]      result
);

  localparam int unsigned ProdW = tnrc_pkg::DiffW + tnrc_pkg::CoefW + 1;
  localparam int unsigned ShW   = ProdW - 16;
  localparam int unsigned DW    = tnrc_pkg::DataW;

  logic signed [tnrc_pkg::CoefW:0] coef_s;
  logic signed [ProdW-1:0]         prod_nxt;
  logic signed [ProdW-1:0]         prod_r;
  logic signed [ProdW-1:0]         rnd;
  logic signed [ShW-1:0]           sh;

  assign coef_s   = {1'b0, coef};
  assign prod_nxt = diff * coef_s;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign rnd = prod_r + ProdW'(32768);
  assign sh  = rnd[ProdW-1:16];

  always_comb begin
    if (sh[ShW-1:DW-1] == {(ShW-DW+1){1'b0}} || sh[ShW-1:DW-1] == {(ShW-DW+1){1'b1}}) begin
      result = sh[DW-1:0];
    end else if (sh[ShW-1]) begin
      result = {1'b1, {(DW-1){1'b0}}};
    end else begin
      result = {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== sv/two_node_thermal_rc_step_top.sv =====
// ----------------------------------------------------------------------------
// Two-node thermal RC stepper
// Advances a chamber/wall/ambient RC network by one time step per sample.
// ----------------------------------------------------------------------------
// Each input transfer carries a heater power sample and an ambient
// temperature, both signed Q16.16. The first transfer after reset only
// primes the history and produces no result. Every later transfer gives one
// result transfer holding the new chamber and wall temperatures.
// An item passes through the accepting cycle and five steps of a sequencer
// that feeds four dependent products through one shared multiplier, each
// product being registered before it is rounded and used. in_ready is low
// from the accepting edge until the result is loaded into the output
// register. While a result waits in that register the block still takes
// the next sample, and only holds before loading its own result.
// The user must write the four coefficients through the APB port only while
// the block is idle; the block itself does not enforce this. Synchronous
// reset restores the coefficient defaults, clears all history and integrals,
// and leaves the block ready with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module two_node_thermal_rc_step_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire tnrc_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output tnrc_pkg::out_item_t                      out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [tnrc_pkg::AddrW-1:0]   paddr,
  input  wire logic        [tnrc_pkg::BusW-1:0]    pwdata,
  output logic             [tnrc_pkg::BusW-1:0]    prdata,
  output logic                                     pready
);

  localparam int unsigned DW = tnrc_pkg::DataW;
  localparam int unsigned CW = tnrc_pkg::CoefW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_Q1   = 3'd1;
  localparam logic [2:0] ST_Q2   = 3'd2;
  localparam logic [2:0] ST_CH   = 3'd3;
  localparam logic [2:0] ST_WL   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic                 primed_r, primed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tnrc_pkg::out_item_t  out_data_r, out_data_nxt;

  logic [CW-1:0] ch_cond_r, wl_cond_r, ch_invc_r, wl_invc_r;

  logic signed [DW-1:0] heat_r, heat_nxt;
  logic signed [DW-1:0] amb_r, amb_nxt;
  logic signed [DW-1:0] last_heat_r, last_heat_nxt;
  logic signed [DW-1:0] last_amb_r, last_amb_nxt;
  logic signed [DW-1:0] heat_int_r, heat_int_nxt;
  logic signed [DW-1:0] ch_state_r, ch_state_nxt;
  logic signed [DW-1:0] wl_state_r, wl_state_nxt;
  logic signed [DW-1:0] in_last_r, in_last_nxt;
  logic signed [DW-1:0] in_sum_r, in_sum_nxt;
  logic signed [DW-1:0] out_last_r, out_last_nxt;
  logic signed [DW-1:0] out_sum_r, out_sum_nxt;

  logic                               mul_load;
  logic signed [tnrc_pkg::DiffW-1:0]  mul_diff;
  logic        [CW-1:0]               mul_coef;
  logic signed [DW-1:0]               scaled;

  logic in_xfer;
  logic cfg_wr;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      tnrc_pkg::REG_CHAMBER_COND: prdata = {{(tnrc_pkg::BusW-CW){1'b0}}, ch_cond_r};
      tnrc_pkg::REG_WALL_COND:    prdata = {{(tnrc_pkg::BusW-CW){1'b0}}, wl_cond_r};
      tnrc_pkg::REG_CHAMBER_INVC: prdata = {{(tnrc_pkg::BusW-CW){1'b0}}, ch_invc_r};
      tnrc_pkg::REG_WALL_INVC:    prdata = {{(tnrc_pkg::BusW-CW){1'b0}}, wl_invc_r};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cond_r <= tnrc_pkg::CHAMBER_COND_RST;
      wl_cond_r <= tnrc_pkg::WALL_COND_RST;
      ch_invc_r <= tnrc_pkg::CHAMBER_INVC_RST;
      wl_invc_r <= tnrc_pkg::WALL_INVC_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tnrc_pkg::REG_CHAMBER_COND: ch_cond_r <= pwdata[CW-1:0];
        tnrc_pkg::REG_WALL_COND:    wl_cond_r <= pwdata[CW-1:0];
        tnrc_pkg::REG_CHAMBER_INVC: ch_invc_r <= pwdata[CW-1:0];
        tnrc_pkg::REG_WALL_INVC:    wl_invc_r <= pwdata[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mul_load = 1'b1;
    case (state_r)
      ST_Q1: begin
        mul_diff = tnrc_pkg::diff33(ch_state_r, wl_state_r);
        mul_coef = ch_cond_r;
      end
      ST_Q2: begin
        mul_diff = tnrc_pkg::diff33(wl_state_r, last_amb_r);
        mul_coef = wl_cond_r;
      end
      ST_CH: begin
        mul_diff = tnrc_pkg::diff33(heat_int_r, in_sum_r);
        mul_coef = ch_invc_r;
      end
      ST_WL: begin
        mul_diff = tnrc_pkg::diff33(in_sum_r, out_sum_r);
        mul_coef = wl_invc_r;
      end
      default: begin
        mul_load = 1'b0;
        mul_diff = '0;
        mul_coef = '0;
      end
    endcase
  end

  tnrc_mul u_mul (
    .clk    (clk),
    .load   (mul_load),
    .diff   (mul_diff),
    .coef   (mul_coef),
    .result (scaled)
  );

  always_comb begin
    state_nxt     = state_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    heat_nxt      = heat_r;
    amb_nxt       = amb_r;
    last_heat_nxt = last_heat_r;
    last_amb_nxt  = last_amb_r;
    heat_int_nxt  = heat_int_r;
    ch_state_nxt  = ch_state_r;
    wl_state_nxt  = wl_state_r;
    in_last_nxt   = in_last_r;
    in_sum_nxt    = in_sum_r;
    out_last_nxt  = out_last_r;
    out_sum_nxt   = out_sum_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!primed_r) begin
            primed_nxt    = 1'b1;
            last_heat_nxt = in_data.heat_input;
            last_amb_nxt  = in_data.ambient_temp;
          end else begin
            heat_nxt  = in_data.heat_input;
            amb_nxt   = in_data.ambient_temp;
            state_nxt = ST_Q1;
          end
        end
      end
      ST_Q1: begin
        heat_int_nxt = tnrc_pkg::trap_acc(heat_int_r, last_heat_r, heat_r);
        state_nxt    = ST_Q2;
      end
      ST_Q2: begin
        in_sum_nxt  = tnrc_pkg::trap_acc(in_sum_r, in_last_r, scaled);
        in_last_nxt = scaled;
        state_nxt   = ST_CH;
      end
      ST_CH: begin
        out_sum_nxt  = tnrc_pkg::trap_acc(out_sum_r, out_last_r, scaled);
        out_last_nxt = scaled;
        state_nxt    = ST_WL;
      end
      ST_WL: begin
        ch_state_nxt = scaled;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          wl_state_nxt              = scaled;
          last_heat_nxt             = heat_r;
          last_amb_nxt              = amb_r;
          out_valid_nxt             = 1'b1;
          out_data_nxt.chamber_temp = ch_state_r;
          out_data_nxt.wall_temp    = scaled;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_heat_r <= '0;
      last_amb_r  <= '0;
      heat_int_r  <= '0;
      ch_state_r  <= '0;
      wl_state_r  <= '0;
      in_last_r   <= '0;
      in_sum_r    <= '0;
      out_last_r  <= '0;
      out_sum_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      last_heat_r <= last_heat_nxt;
      last_amb_r  <= last_amb_nxt;
      heat_int_r  <= heat_int_nxt;
      ch_state_r  <= ch_state_nxt;
      wl_state_r  <= wl_state_nxt;
      in_last_r   <= in_last_nxt;
      in_sum_r    <= in_sum_nxt;
      out_last_r  <= out_last_nxt;
      out_sum_r   <= out_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    heat_r     <= heat_nxt;
    amb_r      <= amb_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/tnrc_checker.sv =====
// ----------------------------------------------------------------------------
// Two-node thermal RC stepper port checker
// Watches the stepper's ports and checks transfer ordering and timing.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrc_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire tnrc_pkg::out_item_t  out_data
);

  logic       seen_r, seen_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    seen_nxt = seen_r || in_xfer;
    pend_nxt = pend_r;
    if (in_xfer && seen_r && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_xfer && !(in_xfer && seen_r)) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      pend_r <= '0;
    end else begin
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready, 1) && !$past(in_ready, 2) && !$past(in_ready, 3))
    else $error("result offered too soon after an input transfer");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pend_r != 2'd0)
    else $error("result transfer without a pending input item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many input items outstanding");

endmodule

bind two_node_thermal_rc_step_top tnrc_checker u_tnrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/two_node_thermal_rc_step_top_tb.sv =====
// ----------------------------------------------------------------------------
// Two-node thermal RC stepper testbench
// Streams heater and ambient samples into the stepper under random gaps and
// output stalls, predicts every chamber and wall temperature with its own
// model of the network, and compares each result transfer against it. The
// four coefficients are rewritten between phases, including the extremes.
// ----------------------------------------------------------------------------
module two_node_thermal_rc_step_top_tb;

  typedef enum int unsigned {
    PLAN_MAX,
    PLAN_ZERO,
    PLAN_WIDE,
    PLAN_MILD,
    PLAN_DEFAULT,
    PLAN_MIXED
  } coef_plan_t;

  typedef struct {
    bit                 primed;
    logic signed [31:0] last_heat;
    logic signed [31:0] last_ambient;
    logic signed [31:0] heat_sum;
    logic signed [31:0] chamber;
    logic signed [31:0] wall;
    logic signed [31:0] inner_last;
    logic signed [31:0] inner_sum;
    logic signed [31:0] outer_last;
    logic signed [31:0] outer_sum;
  } rc_state_t;

  localparam logic [1:0] CoefRegs [4] = '{tnrc_pkg::REG_CHAMBER_COND,
                                          tnrc_pkg::REG_WALL_COND,
                                          tnrc_pkg::REG_CHAMBER_INVC,
                                          tnrc_pkg::REG_WALL_INVC};
  localparam logic [tnrc_pkg::CoefW-1:0] CoefDefaults [4] = '{tnrc_pkg::CHAMBER_COND_RST,
                                                              tnrc_pkg::WALL_COND_RST,
                                                              tnrc_pkg::CHAMBER_INVC_RST,
                                                              tnrc_pkg::WALL_INVC_RST};
  localparam logic signed [31:0] HeatTop = 32'sh7FFFFFFF;
  localparam logic signed [31:0] HeatBottom = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tnrc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tnrc_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tnrc_pkg::AddrW-1:0] paddr = '0;
  logic [tnrc_pkg::BusW-1:0] pwdata = '0;
  logic [tnrc_pkg::BusW-1:0] prdata;
  logic pready;

  two_node_thermal_rc_step_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  rc_state_t rc = '{default: '0};
  logic [tnrc_pkg::CoefW-1:0] coef [4] = CoefDefaults;
  tnrc_pkg::in_item_t pending_samples [$];
  tnrc_pkg::out_item_t awaited_temps [$];
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned results_seen = 0;
  int unsigned saturated_results = 0;
  int unsigned settings_used = 1;
  int unsigned fail_count = 0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return HeatTop;
    if (v < -64'sd2147483648) return HeatBottom;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] rc_product(longint diff,
                                                    logic [tnrc_pkg::CoefW-1:0] k);
    longint gain;
    gain = k;
    return clip32((diff * gain + 32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] trap_step(logic signed [31:0] acc,
                                                   logic signed [31:0] a,
                                                   logic signed [31:0] b);
    longint la;
    longint lb;
    longint lacc;
    la = a;
    lb = b;
    lacc = acc;
    return clip32(lacc + ((la + lb) >>> 1));
  endfunction

  function automatic void advance_network(tnrc_pkg::in_item_t s);
    logic signed [31:0] q1;
    logic signed [31:0] q2;
    longint c;
    longint w;
    longint amb;
    tnrc_pkg::out_item_t temps;
    if (!rc.primed) begin
      rc.last_heat = s.heat_input;
      rc.last_ambient = s.ambient_temp;
      rc.primed = 1'b1;
      return;
    end
    rc.heat_sum = trap_step(rc.heat_sum, rc.last_heat, s.heat_input);
    c = rc.chamber;
    w = rc.wall;
    amb = rc.last_ambient;
    q1 = rc_product(c - w, coef[tnrc_pkg::REG_CHAMBER_COND]);
    rc.inner_sum = trap_step(rc.inner_sum, rc.inner_last, q1);
    rc.inner_last = q1;
    q2 = rc_product(w - amb, coef[tnrc_pkg::REG_WALL_COND]);
    rc.outer_sum = trap_step(rc.outer_sum, rc.outer_last, q2);
    rc.outer_last = q2;
    c = rc.heat_sum;
    w = rc.inner_sum;
    amb = rc.outer_sum;
    rc.chamber = rc_product(c - w, coef[tnrc_pkg::REG_CHAMBER_INVC]);
    rc.wall = rc_product(w - amb, coef[tnrc_pkg::REG_WALL_INVC]);
    rc.last_heat = s.heat_input;
    rc.last_ambient = s.ambient_temp;
    temps.chamber_temp = rc.chamber;
    temps.wall_temp = rc.wall;
    awaited_temps = {awaited_temps, temps};
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return HeatTop;
    if (r < 8) return HeatBottom;
    if (r < 28) return $urandom;
    if (r < 50) return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
    return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
  endfunction

  function automatic logic [31:0] pick_coef(coef_plan_t plan, int unsigned idx);
    case (plan)
      PLAN_MAX: return 32'hFFFFFFFF;
      PLAN_ZERO: return 32'h0;
      PLAN_WIDE: return $urandom;
      PLAN_MILD: return $urandom_range(0, 65536);
      PLAN_DEFAULT: return {8'($urandom), CoefDefaults[idx]};
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'h0;
          1: return 32'h00FFFFFF;
          default: return $urandom_range(0, 65536);
        endcase
      end
    endcase
  endfunction

  function automatic void queue_sample(logic signed [31:0] heat, logic signed [31:0] amb);
    tnrc_pkg::in_item_t s;
    s.heat_input = heat;
    s.ambient_temp = amb;
    pending_samples = {pending_samples, s};
    samples_queued++;
  endfunction

  task automatic write_coef(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(tnrc_pkg::BusW-tnrc_pkg::CoefW){1'b0}},
                    value[tnrc_pkg::CoefW-1:0]}) begin
      $error("prdata: expected %0h, got %0h", value[tnrc_pkg::CoefW-1:0], prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || awaited_temps.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  always @(posedge clk) begin
    tnrc_pkg::out_item_t want;
    in_took = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;
    if (rst_n && psel && penable && pwrite && pready) begin
      coef[paddr[3:2]] = pwdata[tnrc_pkg::CoefW-1:0];
    end
    if (out_took) begin
      results_seen++;
      if (awaited_temps.size() == 0) begin
        $error("result transfer with no result outstanding: %0d %0d",
               out_data.chamber_temp, out_data.wall_temp);
        fail_count++;
      end else begin
        want = awaited_temps.pop_front();
        if (out_data.chamber_temp !== want.chamber_temp) begin
          $error("chamber_temp: expected %0d, got %0d", want.chamber_temp,
                 out_data.chamber_temp);
          fail_count++;
        end
        if (out_data.wall_temp !== want.wall_temp) begin
          $error("wall_temp: expected %0d, got %0d", want.wall_temp, out_data.wall_temp);
          fail_count++;
        end
        if (want.chamber_temp == HeatTop || want.chamber_temp == HeatBottom ||
            want.wall_temp == HeatTop || want.wall_temp == HeatBottom) begin
          saturated_results++;
        end
      end
    end
    if (in_took) begin
      samples_taken++;
      advance_network(in_data);
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_samples.pop_front();
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
    if (rst_n) begin
      if (recv_stall != 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
        recv_stall = pick_gap(recv_calm);
      end
    end
  end

  initial begin
    logic signed [31:0] heat_now;
    logic signed [31:0] amb_now;
    logic [31:0] plan_value;
    coef_plan_t plan;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_sample(HeatBottom, HeatTop);
    queue_sample(32'sd0, 32'sd0);
    queue_sample(HeatTop, HeatBottom);
    repeat (3) queue_sample(HeatTop, HeatTop);
    repeat (4) queue_sample(HeatBottom, HeatBottom);
    queue_sample(-32'sd1, -32'sd1);
    queue_sample(32'sd1, 32'sd1);
    queue_sample(32'sh55555555, 32'shAAAAAAAA);
    queue_sample(32'shAAAAAAAA, 32'sh55555555);
    repeat (3) queue_sample(32'sd65536, 32'sd1310720);
    wait_idle();

    for (int unsigned p = 0; p <= PLAN_MIXED; p++) begin
      plan = coef_plan_t'(p);
      for (int unsigned k = 0; k < 4; k++) begin
        plan_value = pick_coef(plan, k);
        write_coef(CoefRegs[k], plan_value);
      end
      settings_used++;
      @(posedge clk);
      heat_now = pick_level();
      amb_now = pick_level();
      for (int unsigned n = 0; n < 300; n++) begin
        if (n == 150) begin
          wait_idle();
          @(posedge clk);
        end
        if ($urandom_range(0, 99) < 30) heat_now = pick_level();
        if ($urandom_range(0, 99) < 40) amb_now = pick_level();
        queue_sample(heat_now, amb_now);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d sample transfers and %0d result transfers over %0d settings.",
             samples_taken, results_seen, settings_used);
    $display("Results at a saturation limit: %0d.", saturated_results);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
